>>> rtl/oapm_pkg.sv
package oapm_pkg;

	// timer width for time in state and stillness counters
	localparam int TIMER_BITS = 24;
	localparam int TIMEOUT_W  = 24;
	localparam int CMP_W      = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

	// apb register file
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_IDLE_TIMEOUT  = 3'd0;
	localparam logic [2:0] REG_STILL_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_ALERT_HOLD    = 3'd2;
	localparam logic [2:0] REG_WAKE_ACCEL    = 3'd3;
	localparam logic [2:0] REG_STILL_ACCEL   = 3'd4;
	localparam logic [2:0] REG_CLOSE_LIMIT   = 3'd5;
	localparam logic [2:0] REG_MEDIUM_LIMIT  = 3'd6;
	localparam logic [2:0] REG_FAR_LIMIT     = 3'd7;

	localparam logic [23:0] RST_IDLE_TIMEOUT  = 24'd120000;
	localparam logic [23:0] RST_STILL_TIMEOUT = 24'd5000;
	localparam logic [23:0] RST_ALERT_HOLD    = 24'd200;
	localparam logic [15:0] RST_WAKE_ACCEL    = 16'd4915;
	localparam logic [15:0] RST_STILL_ACCEL   = 16'd4301;
	localparam logic [15:0] RST_CLOSE_LIMIT   = 16'd50;
	localparam logic [15:0] RST_MEDIUM_LIMIT  = 16'd100;
	localparam logic [15:0] RST_FAR_LIMIT     = 16'd200;

	// request kinds
	localparam logic [2:0] K_TICK   = 3'd0;
	localparam logic [2:0] K_START  = 3'd1;
	localparam logic [2:0] K_DETECT = 3'd2;
	localparam logic [2:0] K_CLEAR  = 3'd3;
	localparam logic [2:0] K_MOTION = 3'd4;

	// controller states
	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DETECT = 3'd2;
	localparam logic [2:0] ST_ALERT  = 3'd3;
	localparam logic [2:0] ST_SLEEP  = 3'd4;

	// power modes
	localparam logic [1:0] PW_STANDBY = 2'd0;
	localparam logic [1:0] PW_RUN     = 2'd1;
	localparam logic [1:0] PW_DEEP    = 2'd2;

	// posted events
	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_OBSTACLE = 2'd1;
	localparam logic [1:0] EV_MOTION   = 2'd2;

	// obstacle levels
	localparam logic [1:0] LVL_NONE   = 2'd0;
	localparam logic [1:0] LVL_CLOSE  = 2'd1;
	localparam logic [1:0] LVL_MEDIUM = 2'd2;
	localparam logic [1:0] LVL_FAR    = 2'd3;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] idle_timeout_ms;
		logic [TIMEOUT_W-1:0] still_timeout_ms;
		logic [TIMEOUT_W-1:0] alert_hold_ms;
		logic [15:0]          wake_accel;
		logic [15:0]          still_accel;
		logic [15:0]          close_limit;
		logic [15:0]          medium_limit;
		logic [15:0]          far_limit;
	} cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		logic [2:0] kind;
		logic       imu_ok;
		logic       wake;
		logic       still;
		logic [1:0] level;
	} req_t;

	// controller state plus the per-request mute flag
	typedef struct packed {
		logic [2:0]            mode;
		logic [1:0]            power;
		logic [TIMER_BITS-1:0] tis;
		logic                  still_active;
		logic [TIMER_BITS-1:0] still_count;
		logic                  mute;
	} ctl_t;

	// saturating timer increment
	function automatic logic [TIMER_BITS-1:0] sat_inc(logic [TIMER_BITS-1:0] v);
		return (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
	endfunction

	// timer strictly above a timeout register
	function automatic logic timer_gt(logic [TIMER_BITS-1:0] t, logic [TIMEOUT_W-1:0] lim);
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
		a = CMP_W'(t);
		b = CMP_W'(lim);
		return a > b;
	endfunction

	// state change with its side effects, no-op when already there
	function automatic ctl_t go_to(ctl_t s, logic [2:0] nxt);
		ctl_t r;
		r = s;
		if (nxt != s.mode) begin
			r.mode = nxt;
			r.tis  = '0;
			case (nxt)
				ST_IDLE: begin
					r.power = PW_STANDBY;
					r.mute  = 1'b1;
				end
				ST_DETECT: begin
					r.power        = PW_RUN;
					r.mute         = 1'b1;
					r.still_active = 1'b0;
					r.still_count  = '0;
				end
				ST_ALERT: begin
					r.power = PW_RUN;
				end
				ST_SLEEP: begin
					r.power = PW_DEEP;
					r.mute  = 1'b1;
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

endpackage

>>> rtl/oapm_regs.sv
module oapm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [oapm_pkg::ADDR_W-1:0]  paddr,
	input  logic [oapm_pkg::DATA_W-1:0]  pwdata,
	output logic [oapm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output oapm_pkg::cfg_t               cfg
);
	import oapm_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_timeout_ms  <= RST_IDLE_TIMEOUT;
			cfg_q.still_timeout_ms <= RST_STILL_TIMEOUT;
			cfg_q.alert_hold_ms    <= RST_ALERT_HOLD;
			cfg_q.wake_accel       <= RST_WAKE_ACCEL;
			cfg_q.still_accel      <= RST_STILL_ACCEL;
			cfg_q.close_limit      <= RST_CLOSE_LIMIT;
			cfg_q.medium_limit     <= RST_MEDIUM_LIMIT;
			cfg_q.far_limit        <= RST_FAR_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_IDLE_TIMEOUT:  cfg_q.idle_timeout_ms  <= pwdata[TIMEOUT_W-1:0];
				REG_STILL_TIMEOUT: cfg_q.still_timeout_ms <= pwdata[TIMEOUT_W-1:0];
				REG_ALERT_HOLD:    cfg_q.alert_hold_ms    <= pwdata[TIMEOUT_W-1:0];
				REG_WAKE_ACCEL:    cfg_q.wake_accel       <= pwdata[15:0];
				REG_STILL_ACCEL:   cfg_q.still_accel      <= pwdata[15:0];
				REG_CLOSE_LIMIT:   cfg_q.close_limit      <= pwdata[15:0];
				REG_MEDIUM_LIMIT:  cfg_q.medium_limit     <= pwdata[15:0];
				REG_FAR_LIMIT:     cfg_q.far_limit        <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// readback
	always_comb begin
		unique case (idx)
			REG_IDLE_TIMEOUT:  prdata = DATA_W'(cfg_q.idle_timeout_ms);
			REG_STILL_TIMEOUT: prdata = DATA_W'(cfg_q.still_timeout_ms);
			REG_ALERT_HOLD:    prdata = DATA_W'(cfg_q.alert_hold_ms);
			REG_WAKE_ACCEL:    prdata = DATA_W'(cfg_q.wake_accel);
			REG_STILL_ACCEL:   prdata = DATA_W'(cfg_q.still_accel);
			REG_CLOSE_LIMIT:   prdata = DATA_W'(cfg_q.close_limit);
			REG_MEDIUM_LIMIT:  prdata = DATA_W'(cfg_q.medium_limit);
			REG_FAR_LIMIT:     prdata = DATA_W'(cfg_q.far_limit);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> rtl/oapm_front.sv
module oapm_front (
	input  logic [2:0]      kind,
	input  logic [15:0]     range_a,
	input  logic [15:0]     range_b,
	input  logic [15:0]     accel_mag,
	input  logic            imu_ok,
	input  oapm_pkg::cfg_t  cfg,
	output oapm_pkg::req_t  req
);
	import oapm_pkg::*;

	logic [15:0] near_range;
	logic [1:0]  level;

	// nearest nonzero range
	always_comb begin
		if (range_a != '0 && range_b != '0) begin
			near_range = (range_a < range_b) ? range_a : range_b;
		end else if (range_a != '0) begin
			near_range = range_a;
		end else begin
			near_range = range_b;
		end
	end

	// obstacle level from the limits, tested in order
	always_comb begin
		level = LVL_NONE;
		if (near_range != '0) begin
			if (near_range < cfg.close_limit) begin
				level = LVL_CLOSE;
			end else if (near_range < cfg.medium_limit) begin
				level = LVL_MEDIUM;
			end else if (near_range < cfg.far_limit) begin
				level = LVL_FAR;
			end
		end
	end

	// state-independent part of the request
	always_comb begin
		req.kind   = kind;
		req.imu_ok = imu_ok;
		req.wake   = accel_mag > cfg.wake_accel;
		req.still  = accel_mag < cfg.still_accel;
		req.level  = level;
	end

endmodule

>>> rtl/oapm_queue.sv
module oapm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  oapm_pkg::req_t  push_data,
	input  logic            pop,
	output oapm_pkg::req_t  pop_data,
	output logic            full,
	output logic            empty
);
	import oapm_pkg::*;

	req_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/oapm_back.sv
module oapm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  oapm_pkg::cfg_t  cfg,
	input  oapm_pkg::req_t  req,
	input  logic            req_avail,
	output logic            req_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      mode_state,
	output logic [1:0]      power_mode,
	output logic            mute_pulse,
	output logic [1:0]      posted_event,
	output logic [1:0]      obstacle_level
);
	import oapm_pkg::*;

	ctl_t       st_q;
	ctl_t       nx;
	logic [1:0] ev;
	logic [1:0] lvl;
	logic       out_valid_q;
	logic [2:0] mode_q;
	logic [1:0] power_q;
	logic       mute_q;
	logic [1:0] event_q;
	logic [1:0] level_q;

	assign req_pop = req_avail && (!out_valid_q || !out_stall);

	// next state for one request
	always_comb begin
		nx      = st_q;
		nx.mute = 1'b0;
		ev      = EV_NONE;
		lvl     = LVL_NONE;
		unique case (req.kind) inside
			K_START: begin
				nx = go_to(nx, req.imu_ok ? ST_IDLE : ST_DETECT);
			end
			K_DETECT: begin
				nx = go_to(nx, ST_ALERT);
			end
			K_CLEAR, K_MOTION: begin
				nx = go_to(nx, ST_DETECT);
			end
			K_TICK: begin
				nx.tis = sat_inc(nx.tis);
				if (nx.still_active) begin
					nx.still_count = sat_inc(nx.still_count);
				end
				unique case (nx.mode)
					ST_INIT: begin
						nx = go_to(nx, ST_IDLE);
					end
					ST_IDLE: begin
						if (!req.imu_ok) begin
							nx = go_to(nx, ST_DETECT);
						end else if (timer_gt(nx.tis, cfg.idle_timeout_ms)) begin
							nx = go_to(nx, ST_SLEEP);
						end else if (req.wake) begin
							ev = EV_MOTION;
							nx = go_to(nx, ST_DETECT);
						end
					end
					ST_DETECT: begin
						if (req.level != LVL_NONE) begin
							ev  = EV_OBSTACLE;
							lvl = req.level;
							nx  = go_to(nx, ST_ALERT);
						end
						// stillness may override a fresh alert
						if (req.still) begin
							if (!nx.still_active) begin
								nx.still_active = 1'b1;
								nx.still_count  = '0;
							end
							if (timer_gt(nx.still_count, cfg.still_timeout_ms)) begin
								nx.still_active = 1'b0;
								nx.still_count  = '0;
								nx = go_to(nx, ST_IDLE);
							end
						end else begin
							nx.still_active = 1'b0;
							nx.still_count  = '0;
						end
					end
					ST_ALERT: begin
						if (timer_gt(nx.tis, cfg.alert_hold_ms)) begin
							nx = go_to(nx, ST_DETECT);
						end
					end
					ST_SLEEP: begin
						if (req.wake) begin
							nx = go_to(nx, ST_DETECT);
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode         <= ST_INIT;
			st_q.power        <= PW_RUN;
			st_q.tis          <= '0;
			st_q.still_active <= 1'b0;
			st_q.still_count  <= '0;
			st_q.mute         <= 1'b0;
		end else if (req_pop) begin
			st_q <= nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			mode_q  <= nx.mode;
			power_q <= nx.power;
			mute_q  <= nx.mute;
			event_q <= ev;
			level_q <= lvl;
		end
	end

	assign out_valid      = out_valid_q;
	assign mode_state     = mode_q;
	assign power_mode     = power_q;
	assign mute_pulse     = mute_q;
	assign posted_event   = event_q;
	assign obstacle_level = level_q;

endmodule

>>> rtl/obstacle_alert_power_mode_controller_core.sv
// throughput: one request per cycle while out_stall is low; the front writes
// a two-entry queue and the back retires one queued request per cycle into
// the result register, and holds while out_stall holds a valid result
// reset: arst_n empties the queue, clears the result valid flag and the controller
// (init state, run power) and loads the register defaults, asynchronously
module obstacle_alert_power_mode_controller_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [oapm_pkg::ADDR_W-1:0]  paddr,
	input  logic [oapm_pkg::DATA_W-1:0]  pwdata,
	output logic [oapm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   kind,
	input  logic [15:0]                  range_a,
	input  logic [15:0]                  range_b,
	input  logic [15:0]                  accel_mag,
	input  logic                         imu_ok,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   mode_state,
	output logic [1:0]                   power_mode,
	output logic                         mute_pulse,
	output logic [1:0]                   posted_event,
	output logic [1:0]                   obstacle_level
);
	import oapm_pkg::*;

	cfg_t cfg;
	req_t req_in;
	req_t req_q;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic q_push;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// configuration registers
	oapm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// request classification
	oapm_front u_front (
		.kind      (kind),
		.range_a   (range_a),
		.range_b   (range_b),
		.accel_mag (accel_mag),
		.imu_ok    (imu_ok),
		.cfg       (cfg),
		.req       (req_in)
	);

	// decoupling queue
	oapm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (req_in),
		.pop       (q_pop),
		.pop_data  (req_q),
		.full      (q_full),
		.empty     (q_empty)
	);

	// controller and result register
	oapm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.req            (req_q),
		.req_avail      (!q_empty),
		.req_pop        (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.mode_state     (mode_state),
		.power_mode     (power_mode),
		.mute_pulse     (mute_pulse),
		.posted_event   (posted_event),
		.obstacle_level (obstacle_level)
	);

`ifndef ASSERT_OFF
	// a mute pulse only comes with a muting state
	a_mute_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mute_pulse |->
		(mode_state == ST_IDLE || mode_state == ST_DETECT || mode_state == ST_SLEEP))
		else $error("mute pulse outside a muting state");

	// a level is reported only with an obstacle event
	a_level_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && posted_event != EV_OBSTACLE |-> obstacle_level == LVL_NONE)
		else $error("obstacle level without obstacle event");

	// in the sleep state power is deep sleep
	a_power_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_state == ST_SLEEP |-> power_mode == PW_DEEP)
		else $error("sleeping without deep sleep power");

	// nothing retires from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif

endmodule
